// ===== rtl/core/rtot_pkg.sv =====
// Shared types and constants of the read-then-overwrite tracker.
// Used by the tracker cell and the top level; depends on nothing else.
package rtot_pkg;

  localparam int ENTRIES  = 256;
  localparam int CNT_W    = $clog2(ENTRIES + 1);
  localparam int SECTOR_W = 48;
  localparam int SEC_W    = 32;
  localparam int NSEC_W   = 30;
  localparam int BYTES_W  = 32;
  localparam int OW_W     = 32;
  localparam int SUM_W    = 48;
  localparam int USED_W   = 9;
  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 112;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_WIN_EN  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_END = CFG_IDX_W'(1);

  // Payload of one table entry; the valid bit travels beside it.
  typedef struct packed {
    logic [SECTOR_W-1:0] sector;
    logic [SEC_W-1:0]    first_sec;
    logic [NSEC_W-1:0]   first_nsec;
    logic [OW_W-1:0]     count;
    logic [SUM_W-1:0]    byte_sum;
  } entry_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic look;   // compare the broadcast sector
    logic upd;    // apply a write to the matching entry
    logic wr;     // current request is a write
    logic ins;    // shift the chain by one, new entry into cell 0
  } cell_ctrl_t;

endpackage

// ===== rtl/core/read_then_overwrite_tracker.sv =====
// Read-then-overwrite tracker: request sequencer, chain of entry cells,
// result register. Depends on rtot_pkg and rtot_cell.
//
// Usage: each in_ request is one storage I/O record (kind on in_tuser,
// sector, time and byte count on in_tdata). Reads of unknown sectors claim
// a table entry; writes to known sectors raise that entry's overwrite count
// and byte sum. Every request gives exactly one out_ result with the match,
// the running totals and the largest overwrite count.
// The request passes three steps through the cell chain before its result
// is registered: compare in every cell, cell update or chain shift, and
// collection of the matched count. A new request is taken only once the
// result is registered and the block is back in idle, so the block does not
// take a new request before it is through with the last one.
// The cfg_ port writes the window enable (index 0) and window end second
// (index 1); it is always ready and is to be written while the block is
// idle, which the block itself does not enforce. Reset (rst_n low,
// synchronous) empties the table and clears the totals, the window settings,
// the state and the output valid. If the receiver stalls, the finished result
// holds on out_tdata; one more request is taken and worked, then it waits.
module read_then_overwrite_tracker
  import rtot_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [47:0] sector, [79:48] time_sec, [109:80] time_nsec, [141:110] io_bytes
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] io_kind
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [31:0] entry_overwrites, [40:32] entries_used, [72:41] max_overwrites,
  // [104:73] total_ios
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [0] in_window, [1] entry_hit, [2] table_full_drop
  output logic [2:0]            out_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_RES  = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic                win_en_r;
  logic [SEC_W-1:0]    win_end_r;
  logic [1:0]          kind_r;
  logic [SECTOR_W-1:0] sector_r;
  logic [SEC_W-1:0]    tsec_r;
  logic [NSEC_W-1:0]   tnsec_r;
  logic [BYTES_W-1:0]  bytes_r;
  logic                ok_r;
  logic                hit_r;
  logic                drop_r;
  logic [CNT_W-1:0]    used_r;
  logic [OW_W-1:0]     total_r;
  logic [OW_W-1:0]     max_r;

  logic                out_valid_r;
  logic                o_win_r, o_hit_r, o_drop_r;
  logic [OW_W-1:0]     o_ow_r, o_max_r, o_total_r;
  logic [CNT_W-1:0]    o_used_r;

  cell_ctrl_t          ctrl;
  logic [ENTRIES-1:0]  valid_v;
  logic [ENTRIES-1:0]  match_v;
  entry_t              ent_v [ENTRIES];
  logic [OW_W-1:0]     rep_v [ENTRIES];
  entry_t              new_ent;
  logic                any_hit;
  logic                full;
  logic [OW_W-1:0]     ow_or;
  logic [OW_W-1:0]     ow;
  logic                load;
  logic [OW_W-1:0]     max_nxt;
  logic [OW_W-1:0]     total_nxt;

  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  assign any_hit = |match_v;
  assign full    = (used_r >= CNT_W'(ENTRIES));

  always_comb begin
    new_ent.sector     = sector_r;
    new_ent.first_sec  = tsec_r;
    new_ent.first_nsec = tnsec_r;
    new_ent.count      = '0;
    new_ent.byte_sum   = '0;
  end

  always_comb begin
    ctrl.look = (state_r == ST_LOOK);
    ctrl.upd  = (state_r == ST_UPD) && ok_r;
    ctrl.wr   = (kind_r == KIND_WRITE);
    ctrl.ins  = (state_r == ST_UPD) && ok_r && (kind_r == KIND_READ) && !any_hit && !full;
  end

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      if (g == 0) begin : g_head
        rtot_cell u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .ctrl       (ctrl),
          .bc_sector  (sector_r),
          .bc_bytes   (bytes_r),
          .prev_valid (1'b1),
          .prev_ent   (new_ent),
          .valid      (valid_v[g]),
          .ent        (ent_v[g]),
          .match      (match_v[g]),
          .rep        (rep_v[g])
        );
      end else begin : g_body
        rtot_cell u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .ctrl       (ctrl),
          .bc_sector  (sector_r),
          .bc_bytes   (bytes_r),
          .prev_valid (valid_v[g-1]),
          .prev_ent   (ent_v[g-1]),
          .valid      (valid_v[g]),
          .ent        (ent_v[g]),
          .match      (match_v[g]),
          .rep        (rep_v[g])
        );
      end
    end
  endgenerate

  // At most one cell matches, so an OR collects its count.
  always_comb begin
    ow_or = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      ow_or = ow_or | rep_v[i];
    end
  end

  always_comb begin
    ow        = (ok_r && hit_r) ? ow_or : '0;
    max_nxt   = (ok_r && hit_r && (kind_r == KIND_WRITE) && (ow_or > max_r)) ? ow_or : max_r;
    total_nxt = (ok_r && (total_r != '1)) ? total_r + OW_W'(1) : total_r;
    load      = (state_r == ST_RES) && (!out_valid_r || out_tready);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_RES;
      ST_RES: begin
        if (load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      win_en_r    <= 1'b0;
      win_end_r   <= '0;
      used_r      <= '0;
      total_r     <= '0;
      max_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WIN_EN:  win_en_r  <= cfg_data[0];
          CFG_WIN_END: win_end_r <= cfg_data[SEC_W-1:0];
          default: ;
        endcase
      end
      if (ctrl.ins) begin
        used_r <= used_r + CNT_W'(1);
      end
      if (load) begin
        total_r     <= total_nxt;
        max_r       <= max_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      kind_r   <= in_tuser;
      sector_r <= in_tdata[47:0];
      tsec_r   <= in_tdata[79:48];
      tnsec_r  <= in_tdata[109:80];
      bytes_r  <= in_tdata[141:110];
    end
    if (state_r == ST_LOOK) begin
      ok_r <= !(win_en_r && (tsec_r >= win_end_r));
    end
    if (state_r == ST_UPD) begin
      // only reads and writes report a match; other kinds just count
      hit_r  <= any_hit && (kind_r inside {KIND_READ, KIND_WRITE});
      drop_r <= ok_r && (kind_r == KIND_READ) && !any_hit && full;
    end
    if (load) begin
      o_win_r   <= ok_r;
      o_hit_r   <= ok_r && hit_r;
      o_drop_r  <= drop_r;
      o_ow_r    <= ow;
      o_max_r   <= max_nxt;
      o_total_r <= total_nxt;
      o_used_r  <= used_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {o_drop_r, o_hit_r, o_win_r};
  assign out_tdata  = {7'd0, o_total_r, o_max_r, USED_W'(o_used_r), o_ow_r};

endmodule

// ===== rtl/core/rtot_cell.sv =====
// One entry of the tracker table: holds the entry, compares the broadcast
// sector, applies writes, and hands its entry to the next cell on insert.
// Depends on rtot_pkg.
module rtot_cell
  import rtot_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  cell_ctrl_t          ctrl,
  input  logic [SECTOR_W-1:0] bc_sector,
  input  logic [BYTES_W-1:0]  bc_bytes,
  input  logic                prev_valid,
  input  entry_t              prev_ent,
  output logic                valid,
  output entry_t              ent,
  output logic                match,
  output logic [OW_W-1:0]     rep
);

  logic             valid_r;
  entry_t           ent_r;
  logic             match_r;
  logic [OW_W-1:0]  rep_r;
  logic [OW_W-1:0]  cnt_nxt;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_nxt;

  always_comb begin
    cnt_nxt  = (ent_r.count == '1) ? ent_r.count : ent_r.count + OW_W'(1);
    sum_wide = {1'b0, ent_r.byte_sum} + (SUM_W + 1)'(bc_bytes);
    // saturate the byte sum on carry out
    sum_nxt  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      if (ctrl.ins) begin
        valid_r <= prev_valid;
      end
      if (ctrl.look) begin
        match_r <= valid_r && (ent_r.sector == bc_sector);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      ent_r <= prev_ent;
    end else if (ctrl.upd && ctrl.wr && match_r) begin
      ent_r.count    <= cnt_nxt;
      ent_r.byte_sum <= sum_nxt;
    end
    if (ctrl.upd) begin
      if (!match_r) begin
        rep_r <= '0;
      end else if (ctrl.wr) begin
        rep_r <= cnt_nxt;
      end else begin
        rep_r <= ent_r.count;
      end
    end
  end

  assign valid = valid_r;
  assign ent   = ent_r;
  assign match = match_r;
  assign rep   = rep_r;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for read_then_overwrite_tracker: directed table, then
// random phases; results are checked against typed rows or a behavioral copy.
// Depends on rtot_pkg and the tracker RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rtot_pkg::*;

  localparam logic [1:0] KIND_OTHER = 2'd2;
  localparam logic [1:0] KIND_RSVD  = 2'd3;
  localparam int QUIET_LIMIT = 1000;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    logic [1:0]          kind;
    logic [SECTOR_W-1:0] sector;
    logic [SEC_W-1:0]    tsec;
    logic [NSEC_W-1:0]   tnsec;
    logic [BYTES_W-1:0]  nbytes;
  } io_item_t;

  typedef struct packed {
    logic              in_window;
    logic              hit;
    logic [OW_W-1:0]   ow;
    logic [USED_W-1:0] used;
    logic [OW_W-1:0]   max_ow;
    logic [31:0]       total;
    logic              drop;
  } track_res_t;

  typedef enum logic {ROW_IO, ROW_CFG} row_op_t;

  typedef struct {
    row_op_t                op;
    io_item_t               io;
    bit                     typed;
    track_res_t             want;
    logic [CFG_IDX_W-1:0]   cfg_idx;
    logic [CFG_DATA_W-1:0]  cfg_val;
  } dir_row_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [1:0]            in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [2:0]            out_tuser;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  read_then_overwrite_tracker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Shadow of the tracker table and totals.
  logic                win_en  = 1'b0;
  logic [SEC_W-1:0]    win_end = '0;
  logic                tr_valid  [ENTRIES];
  logic [SECTOR_W-1:0] tr_sector [ENTRIES];
  logic [OW_W-1:0]     tr_count  [ENTRIES];
  int                  tr_used   = 0;
  logic [OW_W-1:0]     tr_max    = '0;
  logic [31:0]         tr_total  = '0;

  track_res_t pending_q[$];
  dir_row_t   dir_tab[$];
  logic [SECTOR_W-1:0] sec_pool[$];

  bit  idle_on  = 1'b0;
  bit  hold_req = 1'b0;
  int  n_fail   = 0;
  int  n_sent   = 0;
  int  n_checked = 0;
  int  n_reject = 0;
  int  n_hit    = 0;
  int  n_drop   = 0;

  function automatic track_res_t track_io(io_item_t it);
    track_res_t r;
    int         idx;
    r = '0;
    idx = -1;
    if (!(win_en && it.tsec >= win_end)) begin
      r.in_window = 1'b1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (idx < 0 && tr_valid[i] && tr_sector[i] == it.sector) idx = i;
      end
      if (it.kind == KIND_READ) begin
        if (idx >= 0) begin
          r.hit = 1'b1;
          r.ow  = tr_count[idx];
        end else if (tr_used < ENTRIES) begin
          tr_valid[tr_used]  = 1'b1;
          tr_sector[tr_used] = it.sector;
          tr_count[tr_used]  = '0;
          tr_used++;
        end else begin
          r.drop = 1'b1;
        end
      end else if (it.kind == KIND_WRITE && idx >= 0) begin
        r.hit = 1'b1;
        if (tr_count[idx] != '1) tr_count[idx]++;
        r.ow = tr_count[idx];
        if (r.ow > tr_max) tr_max = r.ow;
      end
      if (tr_total != '1) tr_total++;
    end
    r.used   = USED_W'(tr_used);
    r.max_ow = tr_max;
    r.total  = tr_total;
    return r;
  endfunction

  function automatic track_res_t mk_res(logic iw, logic hit, logic [31:0] ow, int used,
                                        logic [31:0] max_ow, logic [31:0] total, logic drop);
    track_res_t r;
    r.in_window = iw;
    r.hit       = hit;
    r.ow        = ow;
    r.used      = USED_W'(used);
    r.max_ow    = max_ow;
    r.total     = total;
    r.drop      = drop;
    return r;
  endfunction

  function automatic logic [SECTOR_W-1:0] rand48();
    logic [SECTOR_W-1:0] s;
    s[31:0]  = $urandom;
    s[47:32] = 16'($urandom);
    return s;
  endfunction

  function automatic logic [SECTOR_W-1:0] pick_known();
    if (tr_used == 0) return rand48();
    return tr_sector[$urandom_range(0, tr_used - 1)];
  endfunction

  function automatic io_item_t mk_io(logic [1:0] kind, logic [SECTOR_W-1:0] sector,
                                     logic [SEC_W-1:0] tsec);
    io_item_t it;
    int       b;
    it.kind   = kind;
    it.sector = sector;
    it.tsec   = tsec;
    it.tnsec  = NSEC_W'($urandom_range(0, 999999999));
    b = $urandom_range(0, 7);
    it.nbytes = (b == 0) ? '0 : (b == 1) ? '1 : $urandom;
    return it;
  endfunction

  task automatic add_io(logic [1:0] kind, logic [47:0] sector, logic [31:0] tsec,
                        logic [29:0] tnsec, logic [31:0] nbytes, bit typed,
                        track_res_t want);
    dir_row_t row;
    row = '{op: ROW_IO, io: '{kind, sector, tsec, tnsec, nbytes}, typed: typed,
            want: want, cfg_idx: '0, cfg_val: '0};
    dir_tab.push_back(row);
  endtask

  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    dir_row_t row;
    row = '{op: ROW_CFG, io: '0, typed: 1'b0, want: '0, cfg_idx: idx, cfg_val: val};
    dir_tab.push_back(row);
  endtask

  // Entered at a rising edge; returns at the edge where the request was taken.
  task automatic send_io(io_item_t it, bit typed, track_res_t want);
    track_res_t r;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.kind;
    in_tdata  <= {2'b00, it.nbytes, it.tnsec, it.tsec, it.sector};
    do @(posedge clk); while (!in_tready);
    r = track_io(it);
    pending_q.push_back(typed ? want : r);
    n_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WIN_EN:  win_en  = val[0];
      CFG_WIN_END: win_end = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      n_fail++;
    end
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_mon
    track_res_t got;
    track_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.ow        = out_tdata[31:0];
      got.used      = out_tdata[40:32];
      got.max_ow    = out_tdata[72:41];
      got.total     = out_tdata[104:73];
      got.in_window = out_tuser[0];
      got.hit       = out_tuser[1];
      got.drop      = out_tuser[2];
      n_reject += !got.in_window;
      n_hit    += got.hit;
      n_drop   += got.drop;
      if (pending_q.size() == 0) begin
        $error("result with no request outstanding");
        n_fail++;
      end else begin
        want = pending_q.pop_front();
        check_field("in_window", want.in_window, got.in_window);
        check_field("entry_hit", want.hit, got.hit);
        check_field("entry_overwrites", want.ow, got.ow);
        check_field("entries_used", want.used, got.used);
        check_field("max_overwrites", want.max_ow, got.max_ow);
        check_field("total_ios", want.total, got.total);
        check_field("table_full_drop", want.drop, got.drop);
        n_checked++;
      end
    end
  end

  // Watchdog: end the run if no handshake happens for too long.
  int quiet = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("** read_then_overwrite_tracker: FAILED **");
        $finish;
      end
    end
  end

  initial begin : main_seq
    io_item_t         it;
    logic [SEC_W-1:0] e;
    logic [1:0]       kind;
    logic [47:0]      s0;
    logic [47:0]      smax;
    int               k;
    s0   = '0;
    smax = '1;
    for (int i = 0; i < ENTRIES; i++) begin
      tr_valid[i] = 1'b0;
      tr_sector[i] = '0;
      tr_count[i] = '0;
    end

    add_io(KIND_READ,  s0,   0, 0, 0, 1, mk_res(1, 0, 0, 1, 0, 1, 0));
    add_io(KIND_WRITE, s0,   0, 0, '1, 1, mk_res(1, 1, 1, 1, 1, 2, 0));
    add_io(KIND_READ,  s0,   1, 1, 1, 1, mk_res(1, 1, 1, 1, 1, 3, 0));
    add_io(KIND_WRITE, smax, 2, 2, 2, 1, mk_res(1, 0, 0, 1, 1, 4, 0));
    add_io(KIND_OTHER, s0,   3, 3, 3, 1, mk_res(1, 0, 0, 1, 1, 5, 0));
    add_io(KIND_RSVD,  s0,   4, 4, 4, 1, mk_res(1, 0, 0, 1, 1, 6, 0));
    add_io(KIND_READ,  smax, '1, 999999999, '1, 1, mk_res(1, 0, 0, 2, 1, 7, 0));
    add_io(KIND_WRITE, smax, 5, 5, 5, 1, mk_res(1, 1, 1, 2, 1, 8, 0));
    add_io(KIND_WRITE, smax, 6, 6, 6, 1, mk_res(1, 1, 2, 2, 2, 9, 0));
    add_io(KIND_WRITE, s0,   7, 7, 7, 1, mk_res(1, 1, 2, 2, 2, 10, 0));
    add_cfg(CFG_WIN_END, 100);
    add_cfg(CFG_WIN_EN, 1);
    // Window edge: one second before the end passes, the end itself is rejected.
    add_io(KIND_READ,  48'd5, 99,  0, 0, 1, mk_res(1, 0, 0, 3, 2, 11, 0));
    add_io(KIND_READ,  48'd6, 100, 0, 0, 1, mk_res(0, 0, 0, 3, 2, 11, 0));
    add_io(KIND_WRITE, s0,    '1,  0, 9, 1, mk_res(0, 0, 0, 3, 2, 11, 0));
    add_io(KIND_WRITE, s0,    0,   0, 9, 1, mk_res(1, 1, 3, 3, 3, 12, 0));
    add_cfg(CFG_WIN_END, 0);
    add_io(KIND_READ,  48'd7, 0, 0, 0, 1, mk_res(0, 0, 0, 3, 3, 12, 0));
    add_cfg(CFG_WIN_END, '1);
    add_io(KIND_READ,  48'd7, 32'hFFFF_FFFE, 0, 0, 1, mk_res(1, 0, 0, 4, 3, 13, 0));
    add_io(KIND_WRITE, 48'd7, '1, 0, 1, 1, mk_res(0, 0, 0, 4, 3, 13, 0));
    add_cfg(CFG_WIN_EN, 0);
    add_io(KIND_WRITE, 48'd7, '1, 0, 1, 1, mk_res(1, 1, 1, 4, 3, 14, 0));
    add_io(KIND_READ,  48'hAAAA_AAAA_AAAA, 32'hAAAA_AAAA, 30'h2AAA_AAAA, 32'hAAAA_AAAA,
           0, '0);
    add_io(KIND_READ,  48'h5555_5555_5555, 32'h5555_5555, 30'h1555_5555, 32'h5555_5555,
           0, '0);
    add_io(KIND_WRITE, 48'h5555_5555_5555, 0, 0, 0, 0, '0);
    add_io(KIND_RSVD,  48'h5555_5555_5555, 0, 0, 0, 0, '0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].op == ROW_CFG)
        write_reg(dir_tab[i].cfg_idx, dir_tab[i].cfg_val);
      else
        send_io(dir_tab[i].io, dir_tab[i].typed, dir_tab[i].want);
    end

    // Small sector pool so reads and writes keep hitting; window at a random end.
    idle_on = 1'b1;
    e = $urandom;
    write_reg(CFG_WIN_END, e);
    write_reg(CFG_WIN_EN, 1);
    sec_pool.push_back(s0);
    sec_pool.push_back(smax);
    repeat (22) sec_pool.push_back(rand48());
    repeat (200) begin
      k = $urandom_range(0, 19);
      kind = (k < 7) ? KIND_READ : (k < 16) ? KIND_WRITE : (k < 19) ? KIND_OTHER : KIND_RSVD;
      k = $urandom_range(0, 9);
      it = mk_io(kind, sec_pool[$urandom_range(0, sec_pool.size() - 1)],
                 (k == 0) ? e - 1 : (k == 1) ? e : (k == 2) ? e + 1 :
                 (k == 3) ? $urandom : $urandom_range(0, e));
      send_io(it, 0, '0);
    end

    // Fill the table past its size; hold the receiver off early on.
    write_reg(CFG_WIN_EN, 0);
    hold_req = 1'b1;
    repeat (280) begin
      k = $urandom_range(0, 19);
      if (k < 17)
        it = mk_io(KIND_READ, rand48(), $urandom);
      else if (k < 19)
        it = mk_io(KIND_WRITE, pick_known(), $urandom);
      else
        it = mk_io($urandom_range(0, 1) ? KIND_OTHER : KIND_RSVD, pick_known(), $urandom);
      send_io(it, 0, '0);
    end

    // Full table, no idling from here on.
    idle_on = 1'b0;
    write_reg(CFG_WIN_END, '1);
    write_reg(CFG_WIN_EN, 1);
    repeat (60) begin
      k = $urandom_range(0, 19);
      if (k < 6)
        it = mk_io(KIND_READ, rand48(), 0);
      else if (k < 11)
        it = mk_io(KIND_READ, pick_known(), 0);
      else if (k < 18)
        it = mk_io(KIND_WRITE, pick_known(), 0);
      else
        it = mk_io($urandom_range(0, 1) ? KIND_OTHER : KIND_RSVD, pick_known(), 0);
      it.tsec = ($urandom_range(0, 9) == 0) ? '1 : $urandom_range(0, 32'hFFFF_FFFE);
      send_io(it, 0, '0);
    end
    in_tvalid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d requests, checked %0d results: %0d window rejects, %0d hits, %0d drops.",
             n_sent, n_checked, n_reject, n_hit, n_drop);
    $display("Table reached %0d entries; window ends 0, 100, random and all-ones exercised.",
             tr_used);
    if (n_fail == 0)
      $display("** read_then_overwrite_tracker: PASSED **");
    else
      $display("** read_then_overwrite_tracker: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/rtot_pkg.sv
rtl/core/rtot_cell.sv
rtl/core/read_then_overwrite_tracker.sv
sim/tb_top.sv
